// ===== rtl/tct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types, constants and tetrahedron decode for the cell triangulator.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int GRID_SIDE = 1024;
    localparam int COORD_W   = 10;
    localparam int LIMIT_W   = 24;
    localparam int COUNT_W   = 25;
    localparam int NUM_TETRA = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

    localparam logic [12:0] GRID_EDGE = 13'(GRID_SIDE - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic [7:0]         corner_bits;
        logic               first_cell;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_z;
        logic [2:0]         v0_from;
        logic [2:0]         v0_to;
        logic [2:0]         v1_from;
        logic [2:0]         v1_to;
        logic [2:0]         v2_from;
        logic [2:0]         v2_to;
        logic               last_of_cell;
        logic               limit_hit;
    } out_t;

    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   z;
        logic [7:0]           bits;
        logic                 first;
        logic [NUM_TETRA-1:0] mixed;
    } queue_t;

    typedef struct packed {
        logic [2:0] v0_from;
        logic [2:0] v0_to;
        logic [2:0] v1_from;
        logic [2:0] v1_to;
        logic [2:0] v2_from;
        logic [2:0] v2_to;
        logic       two;
    } tri_t;

    // corner i of tetrahedron t sits at bits [3i+2:3i]
    function automatic logic [11:0] tetra_corners(input logic [2:0] t);
        logic [11:0] r;
        begin
            case (t)
                3'd0:    r = {3'd6, 3'd2, 3'd1, 3'd0};
                3'd1:    r = {3'd6, 3'd3, 3'd2, 3'd0};
                3'd2:    r = {3'd6, 3'd7, 3'd3, 3'd0};
                3'd3:    r = {3'd6, 3'd4, 3'd7, 3'd0};
                3'd4:    r = {3'd6, 3'd5, 3'd4, 3'd0};
                3'd5:    r = {3'd6, 3'd1, 3'd5, 3'd0};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic tetra_mixed(input logic [7:0] bits, input logic [2:0] t);
        logic [11:0] c;
        logic [3:0]  o;
        begin
            c = tetra_corners(t);
            for (int i = 0; i < 4; i++)
            begin
                o[i] = bits[c[3*i +: 3]];
            end
            return (|o) && !(&o);
        end
    endfunction

    function automatic tri_t make_tri(input logic [7:0] bits, input logic [2:0] t,
                                      input logic second);
        logic [11:0] c;
        logic [2:0]  occ [4];
        logic [2:0]  emp [4];
        logic [2:0]  nocc;
        logic [2:0]  nemp;
        logic [2:0]  ci;
        tri_t        r;
        begin
            c    = tetra_corners(t);
            nocc = '0;
            nemp = '0;
            for (int i = 0; i < 4; i++)
            begin
                occ[i] = '0;
                emp[i] = '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                ci = c[3*i +: 3];
                if (bits[ci])
                begin
                    occ[nocc[1:0]] = ci;
                    nocc = nocc + 3'd1;
                end
                else
                begin
                    emp[nemp[1:0]] = ci;
                    nemp = nemp + 3'd1;
                end
            end
            r = '0;
            case (nocc)
                3'd1:
                begin
                    r = '{occ[0], emp[0], occ[0], emp[1], occ[0], emp[2], 1'b0};
                end
                3'd3:
                begin
                    r = '{emp[0], occ[0], emp[0], occ[2], emp[0], occ[1], 1'b0};
                end
                3'd2:
                begin
                    if (second)
                        r = '{occ[0], emp[1], occ[1], emp[0], occ[1], emp[1], 1'b1};
                    else
                        r = '{occ[0], emp[0], occ[1], emp[0], occ[0], emp[1], 1'b1};
                end
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/tct_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_front
// Accepts cells and flags the mixed tetrahedra; cells outside the grid get no flags.
// ----------------------------------------------------------------------------
module tct_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tct_pkg::in_t    in_data,
    output logic            q_valid,
    input  logic            q_ready,
    output tct_pkg::queue_t q_data
);
    import tct_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    queue_t               data_reg;
    logic [NUM_TETRA-1:0] mixed;
    logic                 outside;

    always_comb
    begin
        outside = (13'(in_data.cell_x) >= GRID_EDGE) ||
                  (13'(in_data.cell_y) >= GRID_EDGE) ||
                  (13'(in_data.cell_z) >= GRID_EDGE);
        for (int t = 0; t < NUM_TETRA; t++)
        begin
            mixed[t] = tetra_mixed(in_data.corner_bits, 3'(t)) && !outside;
        end
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
            valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= '{in_data.cell_x, in_data.cell_y, in_data.cell_z,
                          in_data.corner_bits, in_data.first_cell, mixed};
    end

endmodule

// ===== rtl/tct_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_queue
// Short FIFO of classified cells between the front and the back.
// ----------------------------------------------------------------------------
module tct_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  tct_pkg::queue_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output tct_pkg::queue_t rd_data
);
    import tct_pkg::*;

    queue_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   wptr_next;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W-1:0]   rptr_next;
    logic [QPTR_W:0]     fill_reg;
    logic [QPTR_W:0]     fill_next;
    logic                push;
    logic                pop;

    assign wr_ready = fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign rd_valid = fill_reg != '0;
    assign rd_data  = mem[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/tct_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_back
// Walks the mixed tetrahedra of a cell, emits one triangle a beat, counts
// faces and halts once the limit is exceeded.
// ----------------------------------------------------------------------------
module tct_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  tct_pkg::queue_t            q_data,
    input  logic [tct_pkg::LIMIT_W-1:0] face_limit,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tct_pkg::out_t              out_data
);
    import tct_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [NUM_TETRA-1:0] mask_reg;
    logic [NUM_TETRA-1:0] mask_next;
    logic                 sub_reg;
    logic                 sub_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 halted_reg;
    logic                 halted_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_t                 out_reg;
    logic [COORD_W-1:0]   x_reg;
    logic [COORD_W-1:0]   y_reg;
    logic [COORD_W-1:0]   z_reg;
    logic [7:0]           bits_reg;

    logic [2:0]           t_sel;
    tri_t                 tri_cur;
    logic [COUNT_W:0]     sum_wide;
    logic [COUNT_W-1:0]   sum;
    logic                 hit;
    logic                 tetra_done;
    logic [NUM_TETRA-1:0] rest;
    logic                 last;
    logic                 fire;
    logic                 pop;
    logic                 halt_eff;

    assign q_ready   = !busy_reg;
    assign pop       = q_valid && !busy_reg;
    assign fire      = busy_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        t_sel = '0;
        for (int t = NUM_TETRA - 1; t >= 0; t--)
        begin
            if (mask_reg[t])
                t_sel = 3'(t);
        end
        tri_cur    = make_tri(bits_reg, t_sel, sub_reg);
        sum_wide   = {1'b0, count_reg} + (COUNT_W + 1)'(tri_cur.two ? 2 : 1);
        sum        = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
        hit        = (face_limit != '0) && (sum > COUNT_W'(face_limit));
        tetra_done = !tri_cur.two || sub_reg;
        rest       = mask_reg & ~(NUM_TETRA'(1) << t_sel);
        last       = tetra_done && (hit || rest == '0);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        mask_next      = mask_reg;
        sub_next       = sub_reg;
        count_next     = count_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg;
        halt_eff       = halted_reg && !q_data.first;
        if (out_ready)
            out_valid_next = 1'b0;
        if (pop)
        begin
            if (q_data.first)
            begin
                count_next  = '0;
                halted_next = 1'b0;
            end
            mask_next = q_data.mixed;
            sub_next  = 1'b0;
            busy_next = !halt_eff && (q_data.mixed != '0);
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            if (tetra_done)
            begin
                count_next = sum;
                mask_next  = rest;
                sub_next   = 1'b0;
                if (hit)
                    halted_next = 1'b1;
            end
            else
                sub_next = 1'b1;
            if (last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mask_reg      <= '0;
            sub_reg       <= 1'b0;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            mask_reg      <= mask_next;
            sub_reg       <= sub_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg    <= q_data.x;
            y_reg    <= q_data.y;
            z_reg    <= q_data.z;
            bits_reg <= q_data.bits;
        end
        if (fire)
            out_reg <= '{x_reg, y_reg, z_reg,
                         tri_cur.v0_from, tri_cur.v0_to,
                         tri_cur.v1_from, tri_cur.v1_to,
                         tri_cur.v2_from, tri_cur.v2_to,
                         last, hit};
    end

endmodule

// ===== rtl/tetra_cell_triangulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetra_cell_triangulator_core
// Marching-tetrahedra triangle emitter for one grid cell per input beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one cell per beat: its
// coordinates, the eight corner occupancy bits and first_cell. Output channel
// (out_valid/out_ready/out_data) gives one triangle per beat, with
// last_of_cell on the final triangle of a cell and limit_hit on the
// triangles of the tetrahedron that pushed the face count past face_limit.
// Cells without triangles give no beat at all.
// An input beat passes the front register, the queue, the sequencer load and
// the output register before its first triangle reaches the output. The back
// sequencer loads a cell, then emits its triangles one per beat while the
// output is not stalled, and takes no new cell until the last one is done;
// a 4-entry queue lets the front keep accepting while the back works.
// cfg_we/cfg_wdata write face_limit; write only while the block is idle.
// Reset clears face_limit, the face counter, the halt flag and the queue.
// When out_ready is low a valid output register holds and the back stalls; the
// front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module tetra_cell_triangulator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tct_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tct_pkg::out_t               out_data,
    input  logic                        cfg_we,
    input  logic [tct_pkg::LIMIT_W-1:0] cfg_wdata
);
    import tct_pkg::*;

    logic               fq_valid;
    logic               fq_ready;
    queue_t             fq_data;
    logic               qb_valid;
    logic               qb_ready;
    queue_t             qb_data;
    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    tct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    tct_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    tct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_data     (qb_data),
        .face_limit (limit_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
